// ===== hdl/unt_pkg.sv =====
// Package for the unique name table: table sizing, operation and status
// codes, and the structs passed between front, back and result queue.
// No dependencies.
`default_nettype none

package unt_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int KEY_W     = 64;
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ENTRIES);

  localparam logic [1:0] FUNC_CREATE = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_LIST   = 2'd2;

  typedef enum logic [1:0] {
    OP_CREATE,
    OP_REMOVE,
    OP_LIST
  } op_e;

  typedef enum logic [2:0] {
    ST_CREATED  = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_LISTED   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_WALK,
    B_MOVE,
    B_REPLY
  } back_state_e;

  typedef struct packed {
    op_e              op;
    logic [KEY_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    status_e          status;
    logic [KEY_W-1:0] name;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/unt_front.sv =====
// Front end of the unique name table: accepts requests, decodes the
// operation code and queues commands for the back end. Uses unt_pkg.
`default_nettype none

module unt_front
  import unt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [1:0]       func_i,
  input  wire logic [KEY_W-1:0] name_key_i,
  output logic                  cmd_valid_o,
  output cmd_t                  cmd_o,
  input  wire logic             cmd_ready_i
);

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int QC_W  = $clog2(CMD_DEPTH + 1);

  cmd_t             slot_q [CMD_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QC_W-1:0]  cnt_q, cnt_d;
  logic             known;
  logic             do_push, do_pop;
  cmd_t             cmd_in;

  // Decode the operation; the unused code is accepted and dropped.
  always_comb begin
    known      = 1'b1;
    cmd_in.key = name_key_i;
    cmd_in.op  = OP_CREATE;
    unique case (func_i)
      FUNC_CREATE: cmd_in.op = OP_CREATE;
      FUNC_REMOVE: cmd_in.op = OP_REMOVE;
      FUNC_LIST:   cmd_in.op = OP_LIST;
      default:     known     = 1'b0;
    endcase
  end

  assign full        = (cnt_q == QC_W'(CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rptr_q];
  assign do_push     = push && !full && known;
  assign do_pop      = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QC_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/unt_back.sv =====
// Back end of the unique name table: name memory, entry count and the
// sequencer walking entries one per cycle unless stalled. Uses unt_pkg.
`default_nettype none

module unt_back
  import unt_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cmd_valid_i,
  input  wire cmd_t  cmd_i,
  output logic       cmd_ready_o,
  output logic       res_push_o,
  output res_t       res_o,
  input  wire logic  res_full_i
);

  logic [KEY_W-1:0] mem [ENTRIES];

  back_state_e      state_q, state_d;
  op_e              op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic             rv_q, rv_d;
  logic [IDX_W-1:0] cur_idx_q, cur_idx_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  status_e          reply_q, reply_d;
  logic [KEY_W-1:0] rdata_q;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [KEY_W-1:0] wdata;
  logic             advance;
  logic             hit;
  logic             last_ent;
  logic [CNT_W-1:0] count_m1;

  assign count_m1 = count_q - CNT_W'(1);
  assign hit      = (rdata_q == key_q);
  assign last_ent = (CNT_W'(cur_idx_q) == count_m1);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    rv_d        = rv_q;
    cur_idx_d   = cur_idx_q;
    pos_d       = pos_q;
    reply_d     = reply_q;
    cmd_ready_o = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = rd_idx_q[IDX_W-1:0];
    we          = 1'b0;
    waddr       = count_q[IDX_W-1:0];
    wdata       = key_q;
    advance     = 1'b0;
    res_push_o  = 1'b0;
    res_o       = '{status: reply_q, name: '0, last: 1'b1};

    unique case (state_q)
      B_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          op_d     = cmd_i.op;
          key_d    = cmd_i.key;
          rd_idx_d = '0;
          rv_d     = 1'b0;
          if (count_q == '0) begin
            if (cmd_i.op == OP_CREATE) begin
              // First entry: store without a scan.
              we      = 1'b1;
              waddr   = '0;
              wdata   = cmd_i.key;
              count_d = CNT_W'(1);
              reply_d = ST_CREATED;
            end else begin
              reply_d = ST_EMPTY;
            end
            state_d = B_REPLY;
          end else begin
            state_d = B_WALK;
          end
        end
      end

      B_WALK: begin
        if (!rv_q) begin
          advance = 1'b1;
        end else begin
          unique case (op_q)
            OP_LIST: begin
              if (!res_full_i) begin
                res_push_o = 1'b1;
                res_o      = '{status: ST_LISTED, name: rdata_q, last: last_ent};
                if (last_ent) begin
                  rv_d    = 1'b0;
                  state_d = B_IDLE;
                end else begin
                  advance = 1'b1;
                end
              end
            end
            OP_CREATE: begin
              if (hit) begin
                reply_d = ST_EXISTS;
                state_d = B_REPLY;
              end else if (last_ent) begin
                if (count_q == CNT_MAX) begin
                  reply_d = ST_FULL;
                end else begin
                  we      = 1'b1;
                  count_d = count_q + CNT_W'(1);
                  reply_d = ST_CREATED;
                end
                state_d = B_REPLY;
              end else begin
                advance = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (hit) begin
                // Fetch the last entry to fill the hole.
                pos_d   = cur_idx_q;
                rd_en   = 1'b1;
                rd_addr = count_m1[IDX_W-1:0];
                state_d = B_MOVE;
              end else if (last_ent) begin
                reply_d = ST_NOTFOUND;
                state_d = B_REPLY;
              end else begin
                advance = 1'b1;
              end
            end
            default: state_d = B_IDLE;
          endcase
        end
        if (advance) begin
          if (rd_idx_q < count_q) begin
            rd_en     = 1'b1;
            rd_idx_d  = rd_idx_q + CNT_W'(1);
            cur_idx_d = rd_idx_q[IDX_W-1:0];
            rv_d      = 1'b1;
          end else begin
            rv_d = 1'b0;
          end
        end
      end

      B_MOVE: begin
        we      = 1'b1;
        waddr   = pos_q;
        wdata   = rdata_q;
        count_d = count_m1;
        reply_d = ST_REMOVED;
        state_d = B_REPLY;
      end

      B_REPLY: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = B_IDLE;
        end
      end

      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      count_q  <= '0;
      rv_q     <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rv_q     <= rv_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    cur_idx_q <= cur_idx_d;
    pos_q     <= pos_d;
    reply_q   <= reply_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/unt_res_queue.sv =====
// Result queue of the unique name table: holds finished result items
// until the consumer pops them. Uses unt_pkg.
`default_nettype none

module unt_res_queue
  import unt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t res_i,
  output logic      full_o,
  input  wire logic pop,
  output logic      empty,
  output res_t      res_o
);

  localparam int PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
  localparam int QC_W  = $clog2(RES_DEPTH + 1);

  res_t             slot_q [RES_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QC_W-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QC_W'(RES_DEPTH));
  assign empty   = (cnt_q == '0);
  assign res_o   = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(RES_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(RES_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QC_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/unique_name_table_unit.sv =====
// Unique name table: a single-level table of up to ENTRIES distinct 64-bit
// names, with create, remove and list requests. Each request with a known
// code gives one result item (a list of a non-empty table gives one per
// stored entry, the final one marked by last_result). A create or remove
// walks the stored names through one comparator fed by the single read
// port of the name memory, one read per cycle; a remove that hits then
// moves the last entry into the hole. A list delivers one entry per cycle
// while the result queue has room. Requests on an empty table finish
// without a scan. The table needs no clearing pass after reset.
// Depends on unt_pkg, unt_front, unt_back and unt_res_queue.
`default_nettype none

module unique_name_table_unit
  import unt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // request side
  input  wire logic             push,
  output logic                  full,
  input  wire logic [1:0]       func_i,
  input  wire logic [KEY_W-1:0] name_key_i,
  // result side
  output logic                  empty,
  input  wire logic             pop,
  output logic [2:0]            status_o,
  output logic [KEY_W-1:0]      entry_name_o,
  output logic                  last_result_o
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_ready;
  logic res_push;
  res_t res_in;
  logic res_full;
  res_t res_out;

  // Front: accept and decode requests, drop unused codes, queue commands.
  unt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .func_i      (func_i),
    .name_key_i  (name_key_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  // Back: scan, append, move-last-into-hole and list over the name memory.
  unt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  // Results wait here so the back end can move on while the consumer stalls.
  unt_res_queue u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .res_i  (res_in),
    .full_o (res_full),
    .pop    (pop),
    .empty  (empty),
    .res_o  (res_out)
  );

  assign status_o      = res_out.status;
  assign entry_name_o  = res_out.name;
  assign last_result_o = res_out.last;

endmodule

`default_nettype wire
